// ===== rtl/ftcr_pkg.sv =====
// ----------------------------------------------------------------------------
// ftcr_pkg
// Shared types, codes and helpers for the frame table clock replacer.
// ----------------------------------------------------------------------------
package ftcr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = 6;
  localparam int CNT_W      = 7;
  localparam int SWEEP_W    = CNT_W + 1;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;

  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam count_t FRAME_COUNT_RST = 7'd64;

  localparam kind_t KIND_ALLOC  = 3'd0;
  localparam kind_t KIND_FREE   = 3'd1;
  localparam kind_t KIND_UNLOCK = 3'd2;
  localparam kind_t KIND_LOCK   = 3'd3;
  localparam kind_t KIND_MARK   = 3'd4;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EVICT   = 2'd1;
  localparam status_t ST_NOFRAME = 2'd2;
  localparam status_t ST_WFAIL   = 2'd3;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_UNLOCK = 3'd2,
    OP_LOCK   = 3'd3,
    OP_MARK   = 3'd4,
    OP_REJECT = 3'd5,
    OP_NOP    = 3'd6
  } op_t;

  typedef struct packed {
    op_t    op;
    frame_t sel;
    logic   wr_ok;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_EVICT = 4'b1000
  } state_t;

  function automatic count_t frames_in_use(count_t fc);
    count_t lim;
    lim = count_t'(NUM_FRAMES);
    return (fc > lim) ? lim : fc;
  endfunction

endpackage

// ===== rtl/ftcr_front.sv =====
// ----------------------------------------------------------------------------
// ftcr_front
// Input register: accepts requests and classifies them into commands.
// ----------------------------------------------------------------------------
module ftcr_front #(
  parameter int PAGE_ID_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ftcr_pkg::count_t        frame_count,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ftcr_pkg::kind_t         kind,
  input  logic [PAGE_ID_BITS-1:0] page_id,
  input  ftcr_pkg::frame_t        frame_sel,
  input  logic                    writeout_ok,
  output logic                    f_valid,
  input  logic                    f_stall,
  output ftcr_pkg::cmd_t          f_cmd,
  output logic [PAGE_ID_BITS-1:0] f_page
);
  import ftcr_pkg::*;

  count_t n;
  cmd_t   cmd_next;
  logic   accept;

  assign n        = frames_in_use(frame_count);
  assign in_stall = f_valid && f_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd_next.sel   = frame_sel;
    cmd_next.wr_ok = writeout_ok;
    case (kind)
      KIND_ALLOC:  cmd_next.op = OP_ALLOC;
      KIND_FREE:   cmd_next.op = OP_FREE;
      KIND_UNLOCK: cmd_next.op = OP_UNLOCK;
      KIND_LOCK:   cmd_next.op = OP_LOCK;
      KIND_MARK:   cmd_next.op = OP_MARK;
      default:     cmd_next.op = OP_NOP;
    endcase
    if (kind inside {KIND_FREE, KIND_UNLOCK, KIND_LOCK, KIND_MARK} &&
        count_t'(frame_sel) >= n) begin
      cmd_next.op = OP_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (!f_stall) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_cmd  <= cmd_next;
      f_page <= page_id;
    end
  end

endmodule

// ===== rtl/ftcr_queue.sv =====
// ----------------------------------------------------------------------------
// ftcr_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ftcr_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             full,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);
  import ftcr_pkg::*;

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = slot[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/ftcr_back.sv =====
// ----------------------------------------------------------------------------
// ftcr_back
// Frame table, clock hand and allocation sequencer with result register.
// ----------------------------------------------------------------------------
module ftcr_back #(
  parameter int PAGE_ID_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ftcr_pkg::count_t        frame_count,
  input  logic                    cmd_valid,
  output logic                    cmd_pop,
  input  ftcr_pkg::cmd_t          cmd,
  input  logic [PAGE_ID_BITS-1:0] cmd_page,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ftcr_pkg::status_t       status,
  output ftcr_pkg::frame_t        frame_out,
  output logic [PAGE_ID_BITS-1:0] victim_page
);
  import ftcr_pkg::*;

  state_t                  state;
  logic [NUM_FRAMES-1:0]   valid_q;
  logic [NUM_FRAMES-1:0]   busy_q;
  logic [NUM_FRAMES-1:0]   acc_q;
  frame_t                  hand;
  count_t                  idx;
  logic [SWEEP_W-1:0]      sweep_cnt;
  logic [PAGE_ID_BITS-1:0] cur_page;
  logic                    cur_wr_ok;
  frame_t                  vic;

  logic [PAGE_ID_BITS-1:0] page_mem [NUM_FRAMES];
  logic [PAGE_ID_BITS-1:0] page_rd;

  count_t n;
  logic   res_free;
  logic   go;
  frame_t sc_f;
  logic   sc_end;
  logic   sc_hit;
  logic   sw_end;
  logic   sw_free;
  frame_t hand_next;
  logic   take_en;
  frame_t take_f;

  assign n         = frames_in_use(frame_count);
  assign res_free  = !out_valid || !out_stall;
  assign go        = (state == S_IDLE) && cmd_valid && res_free;
  assign cmd_pop   = go;
  assign sc_f      = idx[FRAME_W-1:0];
  assign sc_end    = (idx == n);
  assign sc_hit    = !busy_q[sc_f] && !valid_q[sc_f];
  assign sw_end    = (sweep_cnt == {n, 1'b0});
  assign sw_free   = !busy_q[hand] && !valid_q[hand];
  assign hand_next = ((count_t'(hand) + count_t'(1)) >= n) ? '0 : hand + frame_t'(1);

  always_comb begin
    take_en = 1'b0;
    take_f  = vic;
    case (state)
      S_SCAN: begin
        take_en = !sc_end && sc_hit;
        take_f  = sc_f;
      end
      S_SWEEP: begin
        take_en = !sw_end && sw_free;
        take_f  = hand;
      end
      S_EVICT: begin
        take_en = 1'b1;
        take_f  = vic;
      end
      default: begin
        take_en = 1'b0;
        take_f  = vic;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take_en) begin
      page_mem[take_f] <= cur_page;
    end
    page_rd <= page_mem[hand];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid_q   <= '0;
      busy_q    <= '0;
      acc_q     <= '0;
      hand      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (take_en) begin
        valid_q[take_f] <= 1'b1;
        busy_q[take_f]  <= 1'b1;
        acc_q[take_f]   <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (go) begin
            cur_page    <= cmd_page;
            cur_wr_ok   <= cmd.wr_ok;
            out_valid   <= 1'b1;
            status      <= ST_OK;
            frame_out   <= cmd.sel;
            victim_page <= '0;
            case (cmd.op)
              OP_ALLOC: begin
                if (n == '0) begin
                  status    <= ST_NOFRAME;
                  frame_out <= '0;
                end else begin
                  out_valid <= 1'b0;
                  idx       <= '0;
                  state     <= S_SCAN;
                end
              end
              OP_FREE: begin
                valid_q[cmd.sel] <= 1'b0;
                busy_q[cmd.sel]  <= 1'b0;
                acc_q[cmd.sel]   <= 1'b0;
              end
              OP_UNLOCK: busy_q[cmd.sel] <= 1'b0;
              OP_LOCK:   busy_q[cmd.sel] <= 1'b1;
              OP_MARK:   acc_q[cmd.sel]  <= 1'b1;
              OP_REJECT: status <= ST_NOFRAME;
              default:   frame_out <= '0;
            endcase
          end
        end
        S_SCAN: begin
          if (sc_end) begin
            hand      <= (count_t'(hand) >= n) ? '0 : hand;
            sweep_cnt <= '0;
            state     <= S_SWEEP;
          end else if (sc_hit) begin
            out_valid   <= 1'b1;
            status      <= ST_OK;
            frame_out   <= sc_f;
            victim_page <= '0;
            state       <= S_IDLE;
          end else begin
            idx <= idx + count_t'(1);
          end
        end
        S_SWEEP: begin
          if (sw_end) begin
            out_valid   <= 1'b1;
            status      <= ST_NOFRAME;
            frame_out   <= '0;
            victim_page <= '0;
            state       <= S_IDLE;
          end else begin
            hand      <= hand_next;
            sweep_cnt <= sweep_cnt + SWEEP_W'(1);
            if (busy_q[hand]) begin
              state <= S_SWEEP;
            end else if (!valid_q[hand]) begin
              out_valid   <= 1'b1;
              status      <= ST_OK;
              frame_out   <= hand;
              victim_page <= '0;
              state       <= S_IDLE;
            end else if (acc_q[hand]) begin
              acc_q[hand] <= 1'b0;
            end else if (!cur_wr_ok) begin
              out_valid   <= 1'b1;
              status      <= ST_WFAIL;
              frame_out   <= hand;
              victim_page <= '0;
              state       <= S_IDLE;
            end else begin
              vic   <= hand;
              state <= S_EVICT;
            end
          end
        end
        S_EVICT: begin
          out_valid   <= 1'b1;
          status      <= ST_EVICT;
          frame_out   <= vic;
          victim_page <= page_rd;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/frame_table_clock_replacer_core.sv =====
// ----------------------------------------------------------------------------
// frame_table_clock_replacer_core
// Frame table with clock (second chance) page replacement.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with kind, page_id, frame_sel and
// writeout_ok; each request yields one result on out_valid/out_stall with
// status, frame_out and victim_page. frame_count is written over the APB
// port at byte address 0; the user must write it only while the block is
// idle, which the block itself does not enforce. Requests pass an input
// register and a two-entry queue to the table sequencer, which executes one
// request at a time. Free, unlock, lock, mark accessed and rejected requests
// then pass the result register. Allocate adds a scan from frame 0 at one
// frame per cycle over up to n frames, then a clock sweep at one frame per
// cycle over up to 2n frames, and an evict state that reads the victim page
// from the page memory; n = frames in use. Reset frees and unlocks all
// frames, clears the accessed bits, parks the hand at frame 0 and sets
// frame_count to 64. A stalled result holds in the output register; the
// queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
module frame_table_clock_replacer_core #(
  parameter int PAGE_ID_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ftcr_pkg::kind_t         kind,
  input  logic [PAGE_ID_BITS-1:0] page_id,
  input  ftcr_pkg::frame_t        frame_sel,
  input  logic                    writeout_ok,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ftcr_pkg::status_t       status,
  output ftcr_pkg::frame_t        frame_out,
  output logic [PAGE_ID_BITS-1:0] victim_page
);
  import ftcr_pkg::*;

  localparam int QW = CMD_W + PAGE_ID_BITS;

  count_t                  frame_count;
  logic                    f_valid;
  logic                    q_full;
  cmd_t                    f_cmd;
  logic [PAGE_ID_BITS-1:0] f_page;
  logic                    q_valid;
  logic                    q_pop;
  logic [QW-1:0]           q_data;
  cmd_t                    b_cmd;
  logic [PAGE_ID_BITS-1:0] b_page;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, frame_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      frame_count <= pwdata[CNT_W-1:0];
    end
  end

  ftcr_front #(.PAGE_ID_BITS(PAGE_ID_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_count (frame_count),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .page_id     (page_id),
    .frame_sel   (frame_sel),
    .writeout_ok (writeout_ok),
    .f_valid     (f_valid),
    .f_stall     (q_full),
    .f_cmd       (f_cmd),
    .f_page      (f_page)
  );

  ftcr_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .full       (q_full),
    .push_data  ({f_cmd, f_page}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign b_cmd  = q_data[QW-1:PAGE_ID_BITS];
  assign b_page = q_data[PAGE_ID_BITS-1:0];

  ftcr_back #(.PAGE_ID_BITS(PAGE_ID_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_count (frame_count),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .cmd         (b_cmd),
    .cmd_page    (b_page),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .frame_out   (frame_out),
    .victim_page (victim_page)
  );

endmodule

// ===== rtl/ftcr_checker.sv =====
// ----------------------------------------------------------------------------
// ftcr_checker
// Port-level checks for the frame table clock replacer, bound to the core.
// ----------------------------------------------------------------------------
module ftcr_checker #(
  parameter int PAGE_ID_BITS = 20
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite,
  input logic [2:0]              paddr,
  input logic [31:0]             pwdata,
  input logic [31:0]             prdata,
  input logic                    pready,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              status,
  input logic [5:0]              frame_out,
  input logic [PAGE_ID_BITS-1:0] victim_page
);
  import ftcr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(status) && $stable(frame_out) && $stable(victim_page))
    else $error("result changed while stalled");

  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_EVICT |-> victim_page == '0)
    else $error("victim page set without eviction");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(psel && penable && pwrite && pready && !paddr[2]) &&
    !paddr[2] |-> prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0]))
    else $error("frame count readback mismatch");

endmodule

bind frame_table_clock_replacer_core ftcr_checker #(.PAGE_ID_BITS(PAGE_ID_BITS)) u_checker (
  .clk         (clk),
  .rst         (rst),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .frame_out   (frame_out),
  .victim_page (victim_page)
);

// ===== tb/ftcr_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// ftcr_tb_pkg
// Frame table mirror for the clock replacer testbench. It holds a copy of the
// frame table, the clock hand and the frame count. For every accepted request
// it works out the result that the block must return, and it compares each
// result that the block delivers with the oldest one still waiting.
// ----------------------------------------------------------------------------
package ftcr_tb_pkg;

  import ftcr_pkg::*;

  localparam int PAGE_W = 20;

  typedef logic [PAGE_W-1:0] page_t;

  typedef struct {
    status_t status;
    frame_t  frame;
    page_t   victim;
  } outcome_t;

  class frame_table_mirror;

    bit          owned [NUM_FRAMES];
    page_t       owner [NUM_FRAMES];
    bit          touched [NUM_FRAMES];
    bit          locked [NUM_FRAMES];
    int unsigned hand;
    count_t      frame_count;
    outcome_t    pending_outcomes [$];
    int unsigned failures;

    function new();
      for (int i = 0; i < NUM_FRAMES; i++) begin
        owned[i]   = 1'b0;
        owner[i]   = '0;
        touched[i] = 1'b0;
        locked[i]  = 1'b0;
      end
      hand        = 0;
      frame_count = FRAME_COUNT_RST;
      failures    = 0;
    endfunction

    function void set_frame_count(count_t value);
      frame_count = value;
    endfunction

    function int active_frames();
      return (int'(frame_count) > NUM_FRAMES) ? NUM_FRAMES : int'(frame_count);
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void claim(int f, page_t page);
      owned[f]   = 1'b1;
      owner[f]   = page;
      touched[f] = 1'b0;
      locked[f]  = 1'b1;
    endfunction

    function outcome_t allocate(page_t page, bit wr_ok);
      outcome_t r;
      int n;
      int f;
      n = active_frames();
      r.status = ST_NOFRAME;
      r.frame  = '0;
      r.victim = '0;
      for (int i = 0; i < n; i++) begin
        if (!locked[i] && !owned[i]) begin
          claim(i, page);
          r.status = ST_OK;
          r.frame  = frame_t'(i);
          return r;
        end
      end
      if (n == 0) return r;
      if (hand >= n) hand = 0;
      for (int i = 0; i < 2 * n; i++) begin
        f = hand;
        hand = (f + 1 >= n) ? 0 : f + 1;
        if (locked[f]) continue;
        if (!owned[f]) begin
          claim(f, page);
          r.status = ST_OK;
          r.frame  = frame_t'(f);
          return r;
        end
        if (touched[f]) begin
          touched[f] = 1'b0;
          continue;
        end
        r.frame = frame_t'(f);
        if (!wr_ok) begin
          r.status = ST_WFAIL;
          return r;
        end
        r.victim = owner[f];
        r.status = ST_EVICT;
        claim(f, page);
        return r;
      end
      return r;
    endfunction

    function outcome_t predict_outcome(kind_t kind, page_t page, frame_t sel, bit wr_ok);
      outcome_t r;
      int f;
      r.status = ST_OK;
      r.frame  = '0;
      r.victim = '0;
      f = int'(sel);
      case (kind)
        KIND_ALLOC: r = allocate(page, wr_ok);
        KIND_FREE, KIND_UNLOCK, KIND_LOCK, KIND_MARK: begin
          r.frame = sel;
          if (f >= active_frames()) begin
            r.status = ST_NOFRAME;
          end else begin
            case (kind)
              KIND_FREE: begin
                owned[f]   = 1'b0;
                touched[f] = 1'b0;
                locked[f]  = 1'b0;
              end
              KIND_UNLOCK: locked[f] = 1'b0;
              KIND_LOCK:   locked[f] = 1'b1;
              default:     touched[f] = 1'b1;
            endcase
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(kind_t kind, page_t page, frame_t sel, bit wr_ok);
      pending_outcomes.push_back(predict_outcome(kind, page, sel, wr_ok));
    endfunction

    function void check_result(status_t status, frame_t frame, page_t victim);
      outcome_t e;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request waiting: status %0d frame %0d victim %0h",
               status, frame, victim);
        failures++;
        return;
      end
      e = pending_outcomes.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        failures++;
      end
      if (frame !== e.frame) begin
        $error("frame_out: expected %0d, got %0d", e.frame, frame);
        failures++;
      end
      if (victim !== e.victim) begin
        $error("victim_page: expected %0h, got %0h", e.victim, victim);
        failures++;
      end
    endfunction

  endclass

endpackage

// ===== tb/frame_table_clock_replacer_core_tb.sv =====
// ----------------------------------------------------------------------------
// frame_table_clock_replacer_core_tb
// Drives requests into the frame table clock replacer under random idling on
// both channels and checks every result against the frame table mirror. A
// short directed part hits the field extremes, every request kind, writeout
// failure, eviction, an empty table, out-of-range targets, hand wrap and
// count saturation. Random phases follow, each under its own frame count,
// with one long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module frame_table_clock_replacer_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ftcr_pkg::*;
  import ftcr_tb_pkg::*;

  localparam int PHASES         = 10;
  localparam int PHASE_REQUESTS = 83;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam logic [2:0] ADDR_FRAME_COUNT = 3'd0;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  kind_t       kind = KIND_ALLOC;
  page_t       page_id = '0;
  frame_t      frame_sel = '0;
  logic        writeout_ok = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  status_t     status;
  frame_t      frame_out;
  page_t       victim_page;

  frame_table_mirror mirror;
  bit          calm = 1'b0;
  int unsigned hold_ticket = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  frame_table_clock_replacer_core #(.PAGE_ID_BITS(PAGE_W)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .page_id(page_id), .frame_sel(frame_sel), .writeout_ok(writeout_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .frame_out(frame_out), .victim_page(victim_page)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) mirror.check_result(status, frame_out, victim_page);
      if (in_valid && !in_stall) mirror.note_request(kind, page_id, frame_sel, writeout_ok);
    end
  end

  // hold results back in short bursts, or for one long stretch on request
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(kind_t k, page_t page, frame_t sel, bit wr_ok);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    page_id     <= page;
    frame_sel   <= sel;
    writeout_ok <= wr_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(int n);
    kind_t  k;
    frame_t sel;
    int     roll;
    roll = $urandom_range(0, 99);
    if (roll < 35)      k = KIND_ALLOC;
    else if (roll < 60) k = KIND_UNLOCK;
    else if (roll < 75) k = KIND_MARK;
    else if (roll < 85) k = KIND_FREE;
    else if (roll < 94) k = KIND_LOCK;
    else                k = kind_t'(KIND_MARK + $urandom_range(1, 3));
    if (n > 0 && $urandom_range(0, 9) != 0) sel = frame_t'($urandom_range(0, n - 1));
    else                                    sel = frame_t'($urandom);
    send_request(k, page_t'($urandom), sel, $urandom_range(0, 4) != 0);
  endtask

  // drain every outstanding request before touching the register
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_count(count_t value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_FRAME_COUNT;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror.set_frame_count(value);
  endtask

  initial begin
    count_t plan [PHASES];
    int     n;
    plan = '{7'd3, 7'd64, 7'd8, 7'd127, 7'd1, 7'd16, 7'd2, 7'd65, 7'd5, 7'd64};
    mirror = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(KIND_ALLOC, '1, '0, 1'b1);
    send_request(KIND_ALLOC, '0, '1, 1'b0);
    send_request(KIND_LOCK, '0, '1, 1'b0);
    send_request(KIND_MARK, '1, '1, 1'b1);
    send_request(KIND_UNLOCK, '0, '1, 1'b0);
    send_request(KIND_FREE, '0, '1, 1'b1);
    send_request(kind_t'(KIND_MARK + 1), '1, '1, 1'b1);
    send_request(kind_t'(KIND_MARK + 2), '0, '0, 1'b0);
    send_request(kind_t'(KIND_MARK + 3), '1, '1, 1'b1);

    write_frame_count(7'd0);
    send_request(KIND_ALLOC, 20'h5A5A5, '0, 1'b1);
    send_request(KIND_FREE, '0, '0, 1'b0);

    write_frame_count(7'd2);
    send_request(KIND_UNLOCK, '0, 6'd0, 1'b0);
    send_request(KIND_UNLOCK, '0, 6'd1, 1'b0);
    send_request(KIND_MARK, '0, 6'd0, 1'b0);
    send_request(KIND_ALLOC, 20'hA5A5A, '0, 1'b0);
    send_request(KIND_ALLOC, 20'h12345, '0, 1'b1);
    send_request(KIND_LOCK, '0, 6'd1, 1'b0);
    send_request(KIND_ALLOC, 20'h6789A, '0, 1'b1);
    send_request(KIND_UNLOCK, '0, 6'd2, 1'b0);

    write_frame_count(7'd1);
    send_request(KIND_FREE, '0, 6'd0, 1'b0);
    send_request(KIND_ALLOC, 20'hBCDEF, '0, 1'b1);
    send_request(KIND_FREE, '0, '1, 1'b0);

    write_frame_count(7'd127);
    send_request(KIND_ALLOC, 20'h0F0F0, '0, 1'b1);
    send_request(KIND_MARK, '0, '1, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      write_frame_count(plan[p]);
      n = mirror.active_frames();
      if (p == 1) hold_ticket++;
      if (p == PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_REQUESTS; i++) send_random(n);
    end

    wait_drained();
    if (mirror.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
